@@ rtl/gmcp_pkg.sv @@
// gmcp_pkg: widths, reset value and status codes for the gf2m minimal polynomial block
// no dependencies
package gmcp_pkg;
  localparam int MaxDeg = 16;
  localparam int ModW   = 17;
  localparam int ElemW  = 16;
  localparam int PolyW  = 17;
  localparam int LenW   = 5;
  localparam int StW    = 2;
  localparam int DegW   = 5;
  localparam int CntW   = 4;
  localparam int AccW   = 6;

  localparam logic [ModW-1:0] ModReset = 17'd69643;

  localparam logic [StW-1:0] StOk   = 2'd0;
  localparam logic [StW-1:0] StWide = 2'd1;
  localparam logic [StW-1:0] StLoop = 2'd2;
  localparam logic [StW-1:0] StRank = 2'd3;
endpackage

@@ rtl/gf2m_min_char_poly_top.sv @@
// gf2m_min_char_poly_top: minimal and characteristic polynomial of a GF(2^n) element
// uses gmcp_pkg; bit-serial multiplier and a rotating row line for the elimination
//
// channel   ports                                              handshake
// config    cfg_wr_en, cfg_wr_data                             write on cfg_wr_en
// input     start, busy, in_element                            beat on start && !busy
// result    out_valid, out_minimal_poly, out_charact_poly,     one-cycle strobe
//           out_frobenius_len, out_status
//
// one item at a time; the shared multiplier takes one bit per cycle for up to n squarings,
// the powers and the n/l carry-less products; the elimination runs on the row line.
// an element out of range reports in the cycle after start. reset is synchronous and
// restores the modulus register; the receiver cannot stall the result.
module gf2m_min_char_poly_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gmcp_pkg::ModW-1:0]   cfg_wr_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [gmcp_pkg::ElemW-1:0]  in_element,
  output logic                        out_valid,
  output logic [gmcp_pkg::PolyW-1:0]  out_minimal_poly,
  output logic [gmcp_pkg::PolyW-1:0]  out_charact_poly,
  output logic [gmcp_pkg::LenW-1:0]   out_frobenius_len,
  output logic [gmcp_pkg::StW-1:0]    out_status
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQR, S_PWR_WR, S_PWR_MUL, S_ELIM, S_KERN, S_CP
  } state_t;

  localparam int Rows = gmcp_pkg::MaxDeg;
  localparam int PW   = gmcp_pkg::PolyW;
  localparam int DW   = gmcp_pkg::DegW;

  state_t                      state_r;
  logic [gmcp_pkg::ModW-1:0]   mod_r;
  logic [DW-1:0]               n_r;
  logic [gmcp_pkg::ElemW-1:0]  a_r;
  logic [gmcp_pkg::ElemW-1:0]  pw_r;
  logic [DW-1:0]               k_r;
  logic [DW-1:0]               l_r;
  logic [DW-1:0]               j_r;

  logic [PW-1:0]               mul_x_r;
  logic [PW-1:0]               mul_y_r;
  logic [PW-1:0]               mul_acc_r;
  logic [DW-1:0]               mul_bit_r;
  logic                        mul_red_r;
  logic [PW-1:0]               mul_nxt;

  logic [PW-1:0]               rows_r [Rows];
  logic                        used_r [Rows];
  logic [DW-1:0]               pcol_r [Rows];
  logic [PW-1:0]               pivmask_r;
  logic [DW-1:0]               rank_r;
  logic [DW-1:0]               fc_r;
  logic [DW-1:0]               ec_r;
  logic                        efound_r;
  logic                        ffound_r;
  logic [PW-1:0]               epiv_r;
  logic [PW-1:0]               fpiv_r;
  logic [gmcp_pkg::CntW-1:0]   cnt_r;
  logic [PW-1:0]               mp_r;
  logic [gmcp_pkg::AccW-1:0]   accl_r;
  logic [gmcp_pkg::AccW-1:0]   accl_nxt;

  logic                        out_valid_r;
  logic [PW-1:0]               out_mp_r;
  logic [PW-1:0]               out_cp_r;
  logic [gmcp_pkg::LenW-1:0]   out_len_r;
  logic [gmcp_pkg::StW-1:0]    out_st_r;

  logic [DW-1:0]               deg_c;
  logic                        bad_c;
  logic [PW-1:0]               elim_row;
  logic                        is_piv;
  logic                        take;
  logic [DW-1:0]               freecol;
  logic [PW-1:0]               kern;

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_minimal_poly  = out_mp_r;
  assign out_charact_poly  = out_cp_r;
  assign out_frobenius_len = out_len_r;
  assign out_status        = out_st_r;

  always_comb begin
    deg_c = '0;
    for (int i = 1; i < gmcp_pkg::ModW; i++) begin
      if (mod_r[i]) deg_c = DW'(i);
    end
    bad_c = (deg_c == '0) || ((in_element >> deg_c) != '0);
  end

  // one multiplier step, high bit first
  always_comb begin
    mul_nxt = {mul_acc_r[PW-2:0], 1'b0};
    if (mul_red_r && mul_nxt[n_r]) mul_nxt = mul_nxt ^ mod_r;
    if (mul_y_r[mul_bit_r]) mul_nxt = mul_nxt ^ mul_x_r;
  end

  always_comb begin
    is_piv   = used_r[0] && (pcol_r[0] == ec_r);
    elim_row = rows_r[0];
    if (efound_r && !is_piv && rows_r[0][ec_r]) elim_row = rows_r[0] ^ epiv_r;
    take = 1'b0;
    if (!ffound_r && (fc_r <= l_r) && !used_r[0]) take = elim_row[fc_r];
  end

  always_comb begin
    freecol = '0;
    for (int c = PW - 1; c >= 0; c--) begin
      if ((DW'(c) <= l_r) && !pivmask_r[c]) freecol = DW'(c);
    end
    kern = PW'(1) << freecol;
    for (int i = 0; i < Rows; i++) begin
      if (used_r[i] && rows_r[i][freecol]) kern = kern | (PW'(1) << pcol_r[i]);
    end
    accl_nxt = accl_r + gmcp_pkg::AccW'(l_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= gmcp_pkg::ModReset;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) mod_r <= cfg_wr_data;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (bad_c) begin
              out_valid_r <= 1'b1;
              out_mp_r    <= '0;
              out_cp_r    <= '0;
              out_len_r   <= '0;
              out_st_r    <= gmcp_pkg::StWide;
            end else begin
              n_r       <= deg_c;
              a_r       <= in_element;
              mul_x_r   <= PW'(in_element);
              mul_y_r   <= PW'(in_element);
              mul_acc_r <= '0;
              mul_bit_r <= deg_c - 1'b1;
              mul_red_r <= 1'b1;
              k_r       <= DW'(1);
              pivmask_r <= '0;
              rank_r    <= '0;
              for (int i = 0; i < Rows; i++) begin
                rows_r[i] <= '0;
                used_r[i] <= 1'b0;
                pcol_r[i] <= '0;
              end
              state_r   <= S_SQR;
            end
          end
        end
        S_SQR: begin
          mul_acc_r <= mul_nxt;
          mul_bit_r <= mul_bit_r - 1'b1;
          if (mul_bit_r == '0) begin
            if (mul_nxt == PW'(a_r)) begin
              l_r     <= k_r;
              pw_r    <= gmcp_pkg::ElemW'(1);
              j_r     <= '0;
              state_r <= S_PWR_WR;
            end else if (k_r == n_r) begin
              out_valid_r <= 1'b1;
              out_mp_r    <= '0;
              out_cp_r    <= '0;
              out_len_r   <= '0;
              out_st_r    <= gmcp_pkg::StLoop;
              state_r     <= S_IDLE;
            end else begin
              k_r       <= k_r + 1'b1;
              mul_x_r   <= mul_nxt;
              mul_y_r   <= mul_nxt;
              mul_acc_r <= '0;
              mul_bit_r <= n_r - 1'b1;
            end
          end
        end
        S_PWR_WR: begin
          for (int i = 0; i < Rows; i++) begin
            rows_r[i][j_r] <= pw_r[i];
          end
          if (j_r == l_r) begin
            fc_r     <= '0;
            ec_r     <= '0;
            efound_r <= 1'b0;
            ffound_r <= 1'b0;
            cnt_r    <= '0;
            state_r  <= S_ELIM;
          end else begin
            mul_x_r   <= PW'(pw_r);
            mul_y_r   <= PW'(a_r);
            mul_acc_r <= '0;
            mul_bit_r <= n_r - 1'b1;
            state_r   <= S_PWR_MUL;
          end
        end
        S_PWR_MUL: begin
          mul_acc_r <= mul_nxt;
          mul_bit_r <= mul_bit_r - 1'b1;
          if (mul_bit_r == '0) begin
            pw_r    <= mul_nxt[gmcp_pkg::ElemW-1:0];
            j_r     <= j_r + 1'b1;
            state_r <= S_PWR_WR;
          end
        end
        S_ELIM: begin
          // eliminate column ec_r and search a pivot for column fc_r in one pass
          for (int i = 0; i < Rows - 1; i++) begin
            rows_r[i] <= rows_r[i+1];
            used_r[i] <= used_r[i+1];
            pcol_r[i] <= pcol_r[i+1];
          end
          rows_r[Rows-1] <= elim_row;
          used_r[Rows-1] <= used_r[0] | take;
          pcol_r[Rows-1] <= take ? fc_r : pcol_r[0];
          if (take) begin
            ffound_r <= 1'b1;
            fpiv_r   <= elim_row;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            ec_r     <= fc_r;
            epiv_r   <= take ? elim_row : fpiv_r;
            efound_r <= ffound_r | take;
            ffound_r <= 1'b0;
            if (ffound_r | take) begin
              pivmask_r[fc_r] <= 1'b1;
              rank_r          <= rank_r + 1'b1;
            end
            fc_r <= fc_r + 1'b1;
            if (fc_r == l_r + 1'b1) state_r <= S_KERN;
          end
        end
        S_KERN: begin
          if (rank_r != l_r) begin
            out_valid_r <= 1'b1;
            out_mp_r    <= '0;
            out_cp_r    <= '0;
            out_len_r   <= l_r;
            out_st_r    <= gmcp_pkg::StRank;
            state_r     <= S_IDLE;
          end else begin
            mp_r      <= kern;
            mul_x_r   <= PW'(1);
            mul_y_r   <= kern;
            mul_acc_r <= '0;
            mul_bit_r <= DW'(PW - 1);
            mul_red_r <= 1'b0;
            accl_r    <= gmcp_pkg::AccW'(l_r);
            state_r   <= S_CP;
          end
        end
        S_CP: begin
          mul_acc_r <= mul_nxt;
          mul_bit_r <= mul_bit_r - 1'b1;
          if (mul_bit_r == '0) begin
            if (accl_nxt <= gmcp_pkg::AccW'(n_r)) begin
              accl_r    <= accl_nxt;
              mul_x_r   <= mul_nxt;
              mul_acc_r <= '0;
              mul_bit_r <= DW'(PW - 1);
            end else begin
              out_valid_r <= 1'b1;
              out_mp_r    <= mp_r;
              out_cp_r    <= mul_nxt;
              out_len_r   <= l_r;
              out_st_r    <= gmcp_pkg::StOk;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/testbench.sv @@
// testbench: checks gf2m_min_char_poly_top against a built-in predictor of the
// minimal/characteristic polynomial, over several moduli; uses gmcp_pkg and the rtl
`timescale 1ns / 100ps

module testbench;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [gmcp_pkg::ModW-1:0]  cfg_wr_data = '0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [gmcp_pkg::ElemW-1:0] in_element = '0;
  logic                       out_valid;
  logic [gmcp_pkg::PolyW-1:0] out_minimal_poly;
  logic [gmcp_pkg::PolyW-1:0] out_charact_poly;
  logic [gmcp_pkg::LenW-1:0]  out_frobenius_len;
  logic [gmcp_pkg::StW-1:0]   out_status;

  typedef struct packed {
    logic [gmcp_pkg::PolyW-1:0] minp;
    logic [gmcp_pkg::PolyW-1:0] charp;
    logic [gmcp_pkg::LenW-1:0]  flen;
    logic [gmcp_pkg::StW-1:0]   st;
  } poly_res_t;

  typedef struct {
    logic                      is_cfg;
    logic [gmcp_pkg::ModW-1:0] value;
    logic                      typed;
    poly_res_t                 res;
  } stim_row_t;

  poly_res_t                 pending_q[$];
  logic [gmcp_pkg::ModW-1:0] modulus;
  int                        fails = 0;
  int                        idle_cnt = 0;
  int                        send_idle_pct = 13;
  localparam int             IdleLimit = 20000;

  gf2m_min_char_poly_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .busy(busy), .in_element(in_element), .out_valid(out_valid),
    .out_minimal_poly(out_minimal_poly), .out_charact_poly(out_charact_poly),
    .out_frobenius_len(out_frobenius_len), .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int top_bit(logic [31:0] v);
    int d;
    d = -1;
    for (int i = 0; i < 32; i++) if (v[i]) d = i;
    return d;
  endfunction

  function automatic logic [31:0] gf_mul(logic [31:0] x, logic [31:0] y,
                                         logic [31:0] m, int n);
    logic [31:0] r;
    r = '0;
    for (int i = n - 1; i >= 0; i--) begin
      r = r << 1;
      if (r[n]) r ^= m;
      if (y[i]) r ^= x;
    end
    return r;
  endfunction

  function automatic poly_res_t predict_min_char(logic [gmcp_pkg::ElemW-1:0] elem,
                                                 logic [gmcp_pkg::ModW-1:0] m);
    poly_res_t   res;
    int          n, l, r, freecol, e;
    logic [31:0] a, sq, pw, kern, cp, prod, t;
    logic [31:0] rows[gmcp_pkg::MaxDeg];
    int          pivcol[gmcp_pkg::MaxDeg];
    int          p;
    logic        piv;
    res = '0;
    a = 32'(elem);
    n = top_bit(32'(m));
    if (n < 1 || n > gmcp_pkg::MaxDeg || (a >> n) != 0) begin
      res.st = gmcp_pkg::StWide;
      return res;
    end
    l = 0;
    sq = a;
    for (int k = 1; k <= n; k++) begin
      sq = gf_mul(sq, sq, 32'(m), n);
      if (sq == a) begin
        l = k;
        break;
      end
    end
    if (l == 0) begin
      res.st = gmcp_pkg::StLoop;
      return res;
    end
    for (int i = 0; i < gmcp_pkg::MaxDeg; i++) rows[i] = '0;
    pw = 32'd1;
    for (int j = 0; j <= l; j++) begin
      for (int i = 0; i < n; i++) if (pw[i]) rows[i][j] = 1'b1;
      pw = gf_mul(pw, a, 32'(m), n);
    end
    r = 0;
    for (int c = 0; c <= l && r < n; c++) begin
      p = -1;
      for (int i = r; i < n; i++) if (p < 0 && rows[i][c]) p = i;
      if (p >= 0) begin
        t = rows[p];
        rows[p] = rows[r];
        rows[r] = t;
        for (int i = 0; i < n; i++) if (i != r && rows[i][c]) rows[i] ^= rows[r];
        pivcol[r] = c;
        r++;
      end
    end
    res.flen = l[gmcp_pkg::LenW-1:0];
    if (l + 1 - r != 1) begin
      res.st = gmcp_pkg::StRank;
      return res;
    end
    freecol = l;
    for (int c = l; c >= 0; c--) begin
      piv = 1'b0;
      for (int i = 0; i < r; i++) if (pivcol[i] == c) piv = 1'b1;
      if (!piv) freecol = c;
    end
    kern = 32'd1 << freecol;
    for (int i = 0; i < r; i++) if (rows[i][freecol]) kern |= 32'd1 << pivcol[i];
    cp = 32'd1;
    e = n / l;
    for (int k = 0; k < e; k++) begin
      prod = '0;
      for (int i = 0; i < 32; i++) if (kern[i]) prod ^= cp << i;
      cp = prod;
    end
    res.minp = kern[gmcp_pkg::PolyW-1:0];
    res.charp = cp[gmcp_pkg::PolyW-1:0];
    res.st = gmcp_pkg::StOk;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time,
                 {out_minimal_poly, out_charact_poly, out_frobenius_len, out_status});
        fails++;
      end else begin
        poly_res_t want;
        want = pending_q.pop_front();
        if (want.minp !== out_minimal_poly) begin
          $display("%0t: minimal_poly exp %h got %h", $time, want.minp, out_minimal_poly);
          fails++;
        end
        if (want.charp !== out_charact_poly) begin
          $display("%0t: charact_poly exp %h got %h", $time, want.charp, out_charact_poly);
          fails++;
        end
        if (want.flen !== out_frobenius_len) begin
          $display("%0t: frobenius_len exp %0d got %0d", $time, want.flen, out_frobenius_len);
          fails++;
        end
        if (want.st !== out_status) begin
          $display("%0t: status exp %0d got %0d", $time, want.st, out_status);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(logic [gmcp_pkg::ModW-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    modulus = v;
  endtask

  task automatic send_element(logic [gmcp_pkg::ElemW-1:0] elem, logic typed,
                              poly_res_t typed_res);
    poly_res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    want = predict_min_char(elem, modulus);
    if (typed && want !== typed_res) begin
      $display("%0t: table row %h exp %h predictor %h", $time, elem, typed_res, want);
      fails++;
    end
    start <= 1'b1;
    in_element <= elem;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(want);
  endtask

  // gf(2^2) x^2+x+1: element 2 has min poly x^2+x+1, len 2
  stim_row_t stim_table[] = '{
    '{1'b0, 17'h00000, 1'b1, '{17'h2, 17'h10000, 5'd1, gmcp_pkg::StOk}},
    '{1'b0, 17'h00001, 1'b1, '{17'h3, 17'h10001, 5'd1, gmcp_pkg::StOk}},
    '{1'b0, 17'h00002, 1'b0, '0},
    '{1'b0, 17'h0FFFF, 1'b0, '0},
    '{1'b0, 17'h08000, 1'b0, '0},
    '{1'b0, 17'h01234, 1'b0, '0},
    '{1'b1, 17'h00007, 1'b0, '0},
    '{1'b0, 17'h00002, 1'b1, '{17'h7, 17'h7, 5'd2, gmcp_pkg::StOk}},
    '{1'b0, 17'h00003, 1'b1, '{17'h7, 17'h7, 5'd2, gmcp_pkg::StOk}},
    '{1'b0, 17'h00004, 1'b1, '{17'h0, 17'h0, 5'd0, gmcp_pkg::StWide}},
    '{1'b0, 17'h0FFFF, 1'b1, '{17'h0, 17'h0, 5'd0, gmcp_pkg::StWide}},
    '{1'b1, 17'h00005, 1'b0, '0},
    '{1'b0, 17'h00002, 1'b1, '{17'h0, 17'h0, 5'd0, gmcp_pkg::StLoop}},
    '{1'b0, 17'h00001, 1'b0, '0},
    '{1'b1, 17'h1FFFF, 1'b0, '0},
    '{1'b0, 17'h00000, 1'b1, '{17'h2, 17'h10000, 5'd1, gmcp_pkg::StOk}},
    '{1'b1, 17'h00001, 1'b0, '0},
    '{1'b0, 17'h00000, 1'b1, '{17'h0, 17'h0, 5'd0, gmcp_pkg::StWide}},
    '{1'b1, 17'h00000, 1'b0, '0},
    '{1'b0, 17'h00001, 1'b1, '{17'h0, 17'h0, 5'd0, gmcp_pkg::StWide}},
    '{1'b1, 17'h1100B, 1'b0, '0},
    '{1'b0, 17'h0FFFF, 1'b0, '0},
    '{1'b0, 17'h0AAAA, 1'b0, '0},
    '{1'b1, 17'h00013, 1'b0, '0},
    '{1'b0, 17'h00006, 1'b0, '0}
  };

  // irreducible and reducible moduli of several degrees
  logic [gmcp_pkg::ModW-1:0] moduli[] = '{17'h1100B, 17'h0000B, 17'h00013, 17'h00025,
                                          17'h0011B, 17'h00009, 17'h00015, 17'h10001,
                                          17'h1FFFF, 17'h00007, 17'h00211, 17'h0008D,
                                          17'h1002D, 17'h00003};

  initial begin
    int n, items;
    logic [gmcp_pkg::ModW-1:0] m;
    logic [gmcp_pkg::ElemW-1:0] elem;
    modulus = gmcp_pkg::ModReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) write_modulus(stim_table[i].value);
      else send_element(stim_table[i].value[gmcp_pkg::ElemW-1:0], stim_table[i].typed,
                        stim_table[i].res);
    end
    items = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 69 : 0;
      for (int g = 0; g < 10; g++) begin
        if ($urandom_range(3) == 0) m = gmcp_pkg::ModW'($urandom_range(17'h1FFFF));
        else m = moduli[$urandom_range(moduli.size() - 1)];
        write_modulus(m);
        n = top_bit(32'(m));
        for (int k = 0; k < 25; k++) begin
          elem = gmcp_pkg::ElemW'($urandom);
          if (n >= 1 && n <= gmcp_pkg::MaxDeg && $urandom_range(9) != 0)
            elem = elem & gmcp_pkg::ElemW'((32'd1 << n) - 32'd1);
          send_element(elem, 1'b0, '0);
          items++;
        end
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
